[design/tpc_pkg.sv]
// Shared types and constants of the triangle plane clipper.
// No dependencies; every other design file but tpc_fifo refers to it by scoped names.
`default_nettype none

package tpc_pkg;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec_t;     // [0] = x, [1] = y, [2] = z
  typedef vec_t   [2:0] tri_t;     // three vertices in input order
  typedef logic signed [65:0] dot_t;  // exact n.p

  typedef enum logic [1:0] {
    CFG_NX     = 2'd0,
    CFG_NY     = 2'd1,
    CFG_NZ     = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_idx_e;

  localparam coord_t NX_RESET     = 32'sd0;
  localparam coord_t NY_RESET     = 32'sd0;
  localparam coord_t NZ_RESET     = 32'sd65536;
  localparam coord_t OFFSET_RESET = 32'sd0;

  localparam coord_t COORD_MAX = 32'sh7FFF_FFFF;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    coord_t ax; coord_t ay; coord_t az;
    coord_t bx; coord_t by; coord_t bz;
    coord_t cx; coord_t cy; coord_t cz;
  } in_t;

  typedef struct packed {
    coord_t r0x; coord_t r0y; coord_t r0z;
    coord_t r1x; coord_t r1y; coord_t r1z;
    coord_t r2x; coord_t r2y; coord_t r2z;
    logic   was_clipped;
    logic   last_piece;
  } out_t;

  // Classified triangle handed from front to back.
  typedef struct packed {
    tri_t          vtx;
    dot_t [2:0]    dot;
    coord_t        w;
    logic [2:0]    in_mask;
  } mid_t;

  // Edge cut request: p1 outside, p2 inside.
  typedef struct packed {
    logic   start;
    vec_t   p1;
    vec_t   p2;
    dot_t   d1;
    dot_t   d2;
    coord_t w;
  } cut_req_t;

endpackage

`default_nettype wire

[design/tpc_fifo.sv]
// Small register queue with push/full and pop/empty sides.
// Generic; element type and depth come from parameters.
`default_nettype none

module tpc_fifo #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  output logic      full_o,
  input  wire T     data_i,
  input  wire logic pop_i,
  output logic      empty_o,
  output T          data_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/tpc_front.sv]
// Front end: plane registers and the classify pipeline (dot products, inside test).
// Depends on tpc_pkg.
`default_nettype none

module tpc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire tpc_pkg::in_t     tri_i,
  output logic                  mid_push_o,
  input  wire logic             mid_full_i,
  output tpc_pkg::mid_t         mid_data_o
);

  tpc_pkg::coord_t nx_q, ny_q, nz_q, w_q;

  // stage 1: products
  logic               v1_q;
  tpc_pkg::tri_t      vtx1_q;
  tpc_pkg::coord_t    w1_q;
  logic signed [63:0] prod_q [3][3];
  logic signed [63:0] sq_q [3];
  // stage 2: sums
  logic               v2_q;
  tpc_pkg::tri_t      vtx2_q;
  tpc_pkg::coord_t    w2_q;
  tpc_pkg::dot_t      dot2_q [3];
  logic [63:0]        nn_q;
  // stage 3: n.n * w partial products
  logic               v3_q;
  tpc_pkg::tri_t      vtx3_q;
  tpc_pkg::coord_t    w3_q;
  tpc_pkg::dot_t      dot3_q [3];
  logic signed [64:0] nwlo_q, nwhi_q;

  logic adv1, adv2, adv3;
  tpc_pkg::tri_t   vtx_in;
  tpc_pkg::vec_t   nvec;
  logic signed [32:0] nnlo_s, nnhi_s;

  assign adv3   = !v3_q || !mid_full_i;
  assign adv2   = !v2_q || adv3;
  assign adv1   = !v1_q || adv2;
  assign full_o = !adv1;

  assign vtx_in[0] = '{tri_i.az, tri_i.ay, tri_i.ax};
  assign vtx_in[1] = '{tri_i.bz, tri_i.by, tri_i.bx};
  assign vtx_in[2] = '{tri_i.cz, tri_i.cy, tri_i.cx};
  assign nvec      = '{nz_q, ny_q, nx_q};
  assign nnlo_s    = {1'b0, nn_q[31:0]};
  assign nnhi_s    = {1'b0, nn_q[63:32]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= tpc_pkg::NX_RESET;
      ny_q <= tpc_pkg::NY_RESET;
      nz_q <= tpc_pkg::NZ_RESET;
      w_q  <= tpc_pkg::OFFSET_RESET;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (tpc_pkg::cfg_idx_e'(cfg_idx_i))
          tpc_pkg::CFG_NX:     nx_q <= cfg_data_i;
          tpc_pkg::CFG_NY:     ny_q <= cfg_data_i;
          tpc_pkg::CFG_NZ:     nz_q <= cfg_data_i;
          tpc_pkg::CFG_OFFSET: w_q  <= cfg_data_i;
        endcase
      end
      if (adv1) v1_q <= push_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      vtx1_q <= vtx_in;
      w1_q   <= w_q;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[k][c] <= nvec[c] * vtx_in[k][c];
        end
      end
      for (int c = 0; c < 3; c++) begin
        sq_q[c] <= nvec[c] * nvec[c];
      end
    end
    if (adv2) begin
      vtx2_q <= vtx1_q;
      w2_q   <= w1_q;
      for (int k = 0; k < 3; k++) begin
        dot2_q[k] <= 66'(prod_q[k][0]) + 66'(prod_q[k][1]) + 66'(prod_q[k][2]);
      end
      nn_q <= 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    end
    if (adv3) begin
      vtx3_q <= vtx2_q;
      w3_q   <= w2_q;
      for (int k = 0; k < 3; k++) dot3_q[k] <= dot2_q[k];
      nwlo_q <= nnlo_s * w2_q;
      nwhi_q <= nnhi_s * w2_q;
    end
  end

  // inside when dot*2^16 + (n.n)*w > 0
  always_comb begin
    logic signed [99:0] s;
    mid_data_o.vtx = vtx3_q;
    mid_data_o.w   = w3_q;
    for (int k = 0; k < 3; k++) begin
      s = (100'(dot3_q[k]) <<< 16) + (100'(nwhi_q) <<< 32) + 100'(nwlo_q);
      mid_data_o.dot[k]     = dot3_q[k];
      mid_data_o.in_mask[k] = !s[99] && (s != '0);
    end
  end

  assign mid_push_o = v3_q;

endmodule

`default_nettype wire

[design/tpc_cut.sv]
// Edge cut unit: one cut point p1 + trunc(num*v/den) per coordinate, saturated.
// Bit-serial restoring divider, 33 steps. Depends on tpc_pkg.
`default_nettype none

module tpc_cut (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tpc_pkg::cut_req_t req_i,
  output logic                   done_o,
  output tpc_pkg::vec_t          res_o
);

  localparam int QBITS = 33;               // |q| below 2^33 or saturated
  localparam int CW    = $clog2(QBITS);

  typedef enum logic [2:0] {
    C_IDLE, C_ABS, C_MUL, C_ADD, C_CHK, C_DIV, C_FIN
  } cut_state_e;

  cut_state_e state_q;
  logic       done_q;
  logic [CW-1:0] cnt_q;

  tpc_pkg::vec_t      p1_q;
  logic signed [32:0] v_q [3];
  logic signed [67:0] num_q;
  logic signed [66:0] den_q;
  logic [67:0]        nabs_q;
  logic [66:0]        dabs_q;
  logic [32:0]        vabs_q [3];
  logic [2:0]         vzero_q, vneg_q, big_q;
  logic               numzero_q, numneg_q, denzero_q, denneg_q;
  logic [66:0]        plo_q [3], phi_q [3];
  logic [100:0]       rem_q [3];
  logic [100:0]       dsh_q;
  logic [QBITS-1:0]   q_q [3];
  tpc_pkg::vec_t      res_q;

  assign done_o = done_q;
  assign res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: if (req_i.start) state_q <= C_ABS;
        C_ABS:  state_q <= C_MUL;
        C_MUL:  state_q <= C_ADD;
        C_ADD:  state_q <= C_CHK;
        C_CHK: begin
          cnt_q   <= CW'(QBITS - 1);
          state_q <= C_DIV;
        end
        C_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= C_FIN;
        end
        C_FIN: begin
          done_q  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic               neg;
    logic signed [34:0] qs, sum;
    unique case (state_q)
      C_IDLE: if (req_i.start) begin
        p1_q <= req_i.p1;
        for (int c = 0; c < 3; c++) v_q[c] <= 33'(req_i.p2[c]) - 33'(req_i.p1[c]);
        num_q <= -(68'(req_i.d1) + (68'(req_i.w) <<< 16));
        den_q <= 67'(req_i.d2) - 67'(req_i.d1);
      end
      C_ABS: begin
        nabs_q    <= num_q[67] ? 68'(-num_q) : 68'(num_q);
        dabs_q    <= den_q[66] ? 67'(-den_q) : 67'(den_q);
        numzero_q <= (num_q == '0);
        numneg_q  <= num_q[67];
        denzero_q <= (den_q == '0);
        denneg_q  <= den_q[66];
        for (int c = 0; c < 3; c++) begin
          vabs_q[c]  <= v_q[c][32] ? 33'(-v_q[c]) : 33'(v_q[c]);
          vzero_q[c] <= (v_q[c] == '0);
          vneg_q[c]  <= v_q[c][32];
        end
      end
      C_MUL: begin
        for (int c = 0; c < 3; c++) begin
          plo_q[c] <= 67'(nabs_q[33:0]) * 67'(vabs_q[c]);
          phi_q[c] <= 67'(nabs_q[67:34]) * 67'(vabs_q[c]);
        end
      end
      C_ADD: begin
        for (int c = 0; c < 3; c++) rem_q[c] <= 101'(plo_q[c]) + (101'(phi_q[c]) << 34);
      end
      C_CHK: begin
        dsh_q <= {2'b00, dabs_q, 32'd0};
        for (int c = 0; c < 3; c++) begin
          big_q[c] <= (rem_q[c] >= {1'b0, dabs_q, 33'd0});
          q_q[c]   <= '0;
        end
      end
      C_DIV: begin
        dsh_q <= dsh_q >> 1;
        for (int c = 0; c < 3; c++) begin
          if (rem_q[c] >= dsh_q) begin
            rem_q[c] <= rem_q[c] - dsh_q;
            q_q[c]   <= {q_q[c][QBITS-2:0], 1'b1};
          end else begin
            q_q[c]   <= {q_q[c][QBITS-2:0], 1'b0};
          end
        end
      end
      C_FIN: begin
        for (int c = 0; c < 3; c++) begin
          neg = numneg_q ^ vneg_q[c] ^ denneg_q;
          qs  = neg ? -35'(q_q[c]) : 35'(q_q[c]);
          sum = 35'(p1_q[c]) + qs;
          priority if (vzero_q[c] || numzero_q) begin
            res_q[c] <= p1_q[c];
          end else if (denzero_q) begin
            res_q[c] <= (numneg_q == vneg_q[c]) ? tpc_pkg::COORD_MAX : tpc_pkg::COORD_MIN;
          end else if (big_q[c]) begin
            res_q[c] <= neg ? tpc_pkg::COORD_MIN : tpc_pkg::COORD_MAX;
          end else if (!sum[34] && (sum[33:31] != 3'b000)) begin
            res_q[c] <= tpc_pkg::COORD_MAX;
          end else if (sum[34] && (sum[33:31] != 3'b111)) begin
            res_q[c] <= tpc_pkg::COORD_MIN;
          end else begin
            res_q[c] <= sum[31:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/tpc_back.sv]
// Back end: takes classified triangles, runs two cut units, emits pieces.
// Depends on tpc_pkg and tpc_cut.
`default_nettype none

module tpc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mid_empty_i,
  input  wire tpc_pkg::mid_t mid_data_i,
  output logic               mid_pop_o,
  output logic               out_push_o,
  input  wire logic          out_full_i,
  output tpc_pkg::out_t      out_data_o
);

  typedef enum logic [1:0] {B_IDLE, B_CUT, B_EMIT1, B_EMIT2} back_state_e;

  back_state_e state_q;
  tpc_pkg::tri_t vtx_q;
  logic          two_q;
  logic [1:0]    in0_q, in1_q;

  logic [1:0] in0, in1, out0, out1;
  logic       ni_one, ni_two, ni_all;
  logic       start;
  tpc_pkg::cut_req_t req_a, req_b;
  logic       done_a, done_b;
  tpc_pkg::vec_t i1, i2;

  function automatic tpc_pkg::out_t make_out(tpc_pkg::vec_t v0, tpc_pkg::vec_t v1,
                                             tpc_pkg::vec_t v2, logic clip, logic last);
    tpc_pkg::out_t o;
    o.r0x = v0[0]; o.r0y = v0[1]; o.r0z = v0[2];
    o.r1x = v1[0]; o.r1y = v1[1]; o.r1z = v1[2];
    o.r2x = v2[0]; o.r2y = v2[1]; o.r2z = v2[2];
    o.was_clipped = clip;
    o.last_piece  = last;
    return o;
  endfunction

  // inside and outside vertices, each in input order
  always_comb begin
    in0 = 2'd0; in1 = 2'd0; out0 = 2'd0; out1 = 2'd0;
    ni_one = 1'b0; ni_two = 1'b0; ni_all = 1'b0;
    unique case (mid_data_i.in_mask)
      3'b001: begin ni_one = 1'b1; in0 = 2'd0; out0 = 2'd1; out1 = 2'd2; end
      3'b010: begin ni_one = 1'b1; in0 = 2'd1; out0 = 2'd0; out1 = 2'd2; end
      3'b100: begin ni_one = 1'b1; in0 = 2'd2; out0 = 2'd0; out1 = 2'd1; end
      3'b011: begin ni_two = 1'b1; in0 = 2'd0; in1 = 2'd1; out0 = 2'd2; end
      3'b101: begin ni_two = 1'b1; in0 = 2'd0; in1 = 2'd2; out0 = 2'd1; end
      3'b110: begin ni_two = 1'b1; in0 = 2'd1; in1 = 2'd2; out0 = 2'd0; end
      3'b111: ni_all = 1'b1;
      default: ;
    endcase
  end

  assign start = (state_q == B_IDLE) && !mid_empty_i && (ni_one || ni_two);

  always_comb begin
    req_a.start = start;
    req_a.p1    = mid_data_i.vtx[out0];
    req_a.d1    = mid_data_i.dot[out0];
    req_a.p2    = mid_data_i.vtx[in0];
    req_a.d2    = mid_data_i.dot[in0];
    req_a.w     = mid_data_i.w;
    req_b.start = start;
    req_b.w     = mid_data_i.w;
    if (ni_one) begin
      req_b.p1 = mid_data_i.vtx[out1];
      req_b.d1 = mid_data_i.dot[out1];
      req_b.p2 = mid_data_i.vtx[in0];
      req_b.d2 = mid_data_i.dot[in0];
    end else begin
      req_b.p1 = mid_data_i.vtx[out0];
      req_b.d1 = mid_data_i.dot[out0];
      req_b.p2 = mid_data_i.vtx[in1];
      req_b.d2 = mid_data_i.dot[in1];
    end
  end

  tpc_cut u_cut_a (.clk_i, .rst_ni, .req_i(req_a), .done_o(done_a), .res_o(i1));
  tpc_cut u_cut_b (.clk_i, .rst_ni, .req_i(req_b), .done_o(done_b), .res_o(i2));

  always_comb begin
    mid_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_data_o = make_out(i1, i2, vtx_q[in0_q], 1'b1, 1'b1);
    unique case (state_q)
      B_IDLE: begin
        out_data_o = make_out(mid_data_i.vtx[0], mid_data_i.vtx[1], mid_data_i.vtx[2],
                              1'b0, 1'b1);
        if (!mid_empty_i) begin
          out_push_o = ni_all;
          mid_pop_o  = !ni_all || !out_full_i;
        end
      end
      B_EMIT1: begin
        out_push_o = 1'b1;
        if (two_q) out_data_o = make_out(i1, vtx_q[in0_q], vtx_q[in1_q], 1'b1, 1'b0);
      end
      B_EMIT2: begin
        out_push_o = 1'b1;
        out_data_o = make_out(i1, i2, vtx_q[in1_q], 1'b1, 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      unique case (state_q)
        B_IDLE:  if (start) state_q <= B_CUT;
        B_CUT:   if (done_a && done_b) state_q <= B_EMIT1;
        B_EMIT1: if (!out_full_i) state_q <= two_q ? B_EMIT2 : B_IDLE;
        B_EMIT2: if (!out_full_i) state_q <= B_IDLE;
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      vtx_q <= mid_data_i.vtx;
      two_q <= ni_two;
      in0_q <= in0;
      in1_q <= in1;
    end
  end

endmodule

`default_nettype wire

[design/triangle_plane_clipper.sv]
// Top level of the triangle plane clipper: front, mid queue, back, result queue.
// Depends on tpc_pkg, tpc_fifo, tpc_front, tpc_back (and tpc_cut below it).
//
//   channel   transfer when          payload
//   input     push && !full          tri_i  (tpc_pkg::in_t)
//   result    pop && !empty          res_o  (tpc_pkg::out_t)
//   config    cfg_we_i               cfg_idx_i, cfg_data_i
//
// Front: three register stages (products, dot sums, n.n*w) then the inside
// test, one triangle per cycle into a short queue while that queue is not full.
// Triangles that pass whole or vanish leave the back end at one per cycle,
// a passing one only while the result queue is not full. A clipped triangle
// holds the back end while the 33-step bit-serial divider in the two cut units
// runs (both cuts run side by side) and then while its pieces are emitted.
// Reset: async, active low; plane registers take their reset values, queues empty.
// Either side may stall; the queues keep the front filling while the back works.
`default_nettype none

module triangle_plane_clipper #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic          push,
  output logic               full,
  input  wire tpc_pkg::in_t  tri_i,
  output logic               empty,
  input  wire logic          pop,
  output tpc_pkg::out_t      res_o
);

  logic          mid_push, mid_full, mid_pop, mid_empty;
  tpc_pkg::mid_t mid_wdata, mid_rdata;
  logic          out_push, out_full;
  tpc_pkg::out_t out_wdata;

  // classify pipeline plus plane registers
  tpc_front u_front (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i     (push),
    .full_o     (full),
    .tri_i,
    .mid_push_o (mid_push),
    .mid_full_i (mid_full),
    .mid_data_o (mid_wdata)
  );

  // decouples classification from cutting
  tpc_fifo #(.DEPTH(MID_DEPTH), .T(tpc_pkg::mid_t)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i (mid_push), .full_o (mid_full), .data_i (mid_wdata),
    .pop_i  (mid_pop),  .empty_o(mid_empty), .data_o(mid_rdata)
  );

  tpc_back u_back (
    .clk_i, .rst_ni,
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_rdata),
    .mid_pop_o   (mid_pop),
    .out_push_o  (out_push),
    .out_full_i  (out_full),
    .out_data_o  (out_wdata)
  );

  // result queue; holds both pieces of a two-piece triangle
  tpc_fifo #(.DEPTH(OUT_DEPTH), .T(tpc_pkg::out_t)) u_out_q (
    .clk_i, .rst_ni,
    .push_i (out_push), .full_o (out_full), .data_i (out_wdata),
    .pop_i  (pop),      .empty_o(empty),    .data_o (res_o)
  );

  // a whole triangle is always its own last piece
  a_pass_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !res_o.was_clipped) |-> res_o.last_piece)
    else $error("passed triangle without last_piece");

  // back end never pops a record it cannot see
  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("mid queue popped while empty");

  // a non-final piece is followed by more results
  a_piece_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_push && !out_full && !out_wdata.last_piece) |=> (out_push || out_full))
    else $error("first piece not followed by second");

endmodule

`default_nettype wire
